// File: rtl/u16u8_pkg.sv
package u16u8_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int MAX_BYTES       = 6;

	localparam logic [15:0] SURR_HIGH_LO = 16'hD800;
	localparam logic [15:0] SURR_HIGH_HI = 16'hDBFF;
	localparam logic [15:0] SURR_LOW_LO  = 16'hDC00;
	localparam logic [15:0] SURR_LOW_HI  = 16'hDFFF;
	localparam logic [15:0] ONE_BYTE_LIM = 16'h0080;
	localparam logic [15:0] TWO_BYTE_LIM = 16'h0800;
	localparam logic [20:0] SUPP_BASE    = 21'h10000;
	localparam logic [15:0] CAP_RESET    = 16'hFFFF;

	localparam logic [1:0] CAUSE_DONE  = 2'd0;
	localparam logic [1:0] CAUSE_ROOM  = 2'd1;
	localparam logic [1:0] CAUSE_TRAIL = 2'd2;

	// everything one accepted word turns into
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                nbytes;
		logic                      has_status;
		logic [1:0]                cause;
		logic [15:0]               units;
		logic [15:0]               written;
	} job_t;

endpackage

// File: rtl/u16u8_front.sv
module u16u8_front #(
	parameter int COUNT_WIDTH = u16u8_pkg::COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       code_unit,
	input  logic              first_unit,
	input  logic              last_unit,
	input  logic              q_full,
	output logic              push,
	output u16u8_pkg::job_t   job
);

	localparam int CW   = COUNT_WIDTH;
	localparam int CapW = (CW > 16) ? CW : 16;

	logic [15:0]   capacity_q;
	logic [15:0]   held_high_q;
	logic          held_valid_q;
	logic [CW-1:0] byte_count_q;
	logic [CW-1:0] unit_count_q;
	logic          stopped_q;

	logic [CapW-1:0] cap_ext;
	logic [CapW-1:0] lim_ext;
	logic [CW-1:0]   eff_cap;

	logic [15:0]   nxt_held;
	logic          nxt_held_v;
	logic [CW-1:0] nxt_bc;
	logic [CW-1:0] nxt_uc;
	logic          nxt_stp;
	logic          accept;

	function automatic logic fits(input logic [CW-1:0] b, input logic [CW-1:0] e,
		input logic [2:0] s);
		return ({1'b0, b} + (CW+1)'(s)) <= {1'b0, e};
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;

	// counts never wrap: clamp capacity to the count range
	assign cap_ext = CapW'(capacity_q);
	assign lim_ext = CapW'({CW{1'b1}});
	assign eff_cap = CW'((cap_ext < lim_ext) ? cap_ext : lim_ext);

	always_comb begin
		logic          stp;
		logic          stop_now;
		logic          is_low;
		logic          is_high;
		logic [2:0]    n;
		logic [20:0]   cp;
		u16u8_pkg::job_t j;

		j          = '0;
		n          = '0;
		stop_now   = 1'b0;
		cp         = {1'b0, held_high_q[9:0], code_unit[9:0]} + u16u8_pkg::SUPP_BASE;
		nxt_held   = first_unit ? 16'h0 : held_high_q;
		nxt_held_v = first_unit ? 1'b0 : held_valid_q;
		nxt_bc     = first_unit ? '0 : byte_count_q;
		nxt_uc     = first_unit ? '0 : unit_count_q;
		stp        = first_unit ? 1'b0 : stopped_q;
		nxt_stp    = stp;
		is_low     = code_unit inside {[u16u8_pkg::SURR_LOW_LO:u16u8_pkg::SURR_LOW_HI]};
		is_high    = code_unit inside {[u16u8_pkg::SURR_HIGH_LO:u16u8_pkg::SURR_HIGH_HI]};

		if (!stp) begin
			if (nxt_held_v) begin
				if (is_low) begin
					stop_now = 1'b1;
					if (!fits(nxt_bc, eff_cap, 3'd4)) begin
						j.has_status = 1'b1;
						j.cause      = u16u8_pkg::CAUSE_ROOM;
					end else begin
						j.bytes[0]  = {5'b11110, cp[20:18]};
						j.bytes[1]  = {2'b10, cp[17:12]};
						j.bytes[2]  = {2'b10, cp[11:6]};
						j.bytes[3]  = {2'b10, cp[5:0]};
						n           = 3'd4;
						nxt_bc      = nxt_bc + CW'(4);
						nxt_uc      = nxt_uc + CW'(2);
						nxt_held_v  = 1'b0;
						nxt_held    = 16'h0;
						if (last_unit) begin
							j.has_status = 1'b1;
							j.cause      = u16u8_pkg::CAUSE_DONE;
						end
					end
				end else if (!fits(nxt_bc, eff_cap, 3'd3)) begin
					stop_now     = 1'b1;
					j.has_status = 1'b1;
					j.cause      = u16u8_pkg::CAUSE_ROOM;
				end else begin
					// unpaired high surrogate goes out on its own
					j.bytes[0] = {4'hE, nxt_held[15:12]};
					j.bytes[1] = {2'b10, nxt_held[11:6]};
					j.bytes[2] = {2'b10, nxt_held[5:0]};
					n          = 3'd3;
					nxt_bc     = nxt_bc + CW'(3);
					nxt_uc     = nxt_uc + CW'(1);
					nxt_held_v = 1'b0;
					nxt_held   = 16'h0;
				end
			end
			if (!stop_now) begin
				if (code_unit < u16u8_pkg::ONE_BYTE_LIM) begin
					if (!fits(nxt_bc, eff_cap, 3'd1)) begin
						stop_now     = 1'b1;
						j.has_status = 1'b1;
						j.cause      = u16u8_pkg::CAUSE_ROOM;
					end else begin
						j.bytes[n] = code_unit[7:0];
						n          = n + 3'd1;
						nxt_bc     = nxt_bc + CW'(1);
						nxt_uc     = nxt_uc + CW'(1);
					end
				end else if (code_unit < u16u8_pkg::TWO_BYTE_LIM) begin
					if (!fits(nxt_bc, eff_cap, 3'd2)) begin
						stop_now     = 1'b1;
						j.has_status = 1'b1;
						j.cause      = u16u8_pkg::CAUSE_ROOM;
					end else begin
						j.bytes[n]        = {3'b110, code_unit[10:6]};
						j.bytes[n + 3'd1] = {2'b10, code_unit[5:0]};
						n                 = n + 3'd2;
						nxt_bc            = nxt_bc + CW'(2);
						nxt_uc            = nxt_uc + CW'(1);
					end
				end else if (is_high) begin
					if (last_unit) begin
						stop_now     = 1'b1;
						j.has_status = 1'b1;
						j.cause      = u16u8_pkg::CAUSE_TRAIL;
					end else begin
						nxt_held   = code_unit;
						nxt_held_v = 1'b1;
					end
				end else begin
					if (!fits(nxt_bc, eff_cap, 3'd3)) begin
						stop_now     = 1'b1;
						j.has_status = 1'b1;
						j.cause      = u16u8_pkg::CAUSE_ROOM;
					end else begin
						j.bytes[n]        = {4'hE, code_unit[15:12]};
						j.bytes[n + 3'd1] = {2'b10, code_unit[11:6]};
						j.bytes[n + 3'd2] = {2'b10, code_unit[5:0]};
						n                 = n + 3'd3;
						nxt_bc            = nxt_bc + CW'(3);
						nxt_uc            = nxt_uc + CW'(1);
					end
				end
				if (!stop_now && last_unit) begin
					j.has_status = 1'b1;
					j.cause      = u16u8_pkg::CAUSE_DONE;
				end
			end
			if (j.has_status) begin
				nxt_stp   = 1'b1;
				j.units   = 16'(nxt_uc);
				j.written = 16'(nxt_bc);
			end
		end
		j.nbytes = n;
		job      = j;
	end

	assign push = accept && ((job.nbytes != 3'd0) || job.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= u16u8_pkg::CAP_RESET;
			held_high_q  <= 16'h0;
			held_valid_q <= 1'b0;
			byte_count_q <= '0;
			unit_count_q <= '0;
			stopped_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if (accept) begin
				held_high_q  <= nxt_held;
				held_valid_q <= nxt_held_v;
				byte_count_q <= nxt_bc;
				unit_count_q <= nxt_uc;
				stopped_q    <= nxt_stp;
			end
		end
	end

	a_held_is_high: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> (held_high_q >= u16u8_pkg::SURR_HIGH_LO &&
			held_high_q <= u16u8_pkg::SURR_HIGH_HI))
		else $error("held unit is not a high surrogate");

endmodule

// File: rtl/u16u8_queue.sv
module u16u8_queue #(
	parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u16u8_pkg::job_t wr_job,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output u16u8_pkg::job_t rd_job
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	u16u8_pkg::job_t entries_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full   = count_q == CntW'(DEPTH);
	assign empty  = count_q == '0;
	assign rd_job = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

// File: rtl/u16u8_back.sv
module u16u8_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  u16u8_pkg::job_t q_job,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            is_status,
	output logic [1:0]      stop_cause,
	output logic [15:0]     units_consumed,
	output logic [15:0]     bytes_written,
	output logic            last_in_run
);

	u16u8_pkg::job_t cur_q;
	logic            cur_valid_q;
	logic [2:0]      idx_q;
	logic [2:0]      total;
	logic            is_data;
	logic            at_end;
	logic            free;

	assign total   = cur_q.nbytes + {2'b00, cur_q.has_status};
	assign is_data = idx_q < cur_q.nbytes;
	assign at_end  = idx_q == total - 3'd1;
	// slot frees up when empty or when its final word leaves
	assign free    = !cur_valid_q || (out_ready && at_end);
	assign pop     = free && !q_empty;

	assign out_valid      = cur_valid_q;
	assign out_byte       = is_data ? cur_q.bytes[idx_q] : 8'h00;
	assign is_status      = !is_data;
	assign stop_cause     = is_data ? u16u8_pkg::CAUSE_DONE : cur_q.cause;
	assign units_consumed = is_data ? 16'h0 : cur_q.units;
	assign bytes_written  = is_data ? 16'h0 : cur_q.written;
	assign last_in_run    = at_end;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (free) begin
				cur_valid_q <= !q_empty;
				idx_q       <= '0;
			end else if (out_ready) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_status) |-> last_in_run)
		else $error("status word is not the last of its run");

endmodule

// File: rtl/utf16_to_utf8_encoder_top.sv
// utf-16 to utf-8 encoder
// in channel (in_valid/in_ready): one code unit a word, with first_unit opening a
// buffer and last_unit closing it. out channel (out_valid/out_ready): one result
// word a cycle while out_ready is high: a utf-8 byte or an end-of-buffer status
// (is_status) that carries stop_cause, units_consumed and bytes_written; last_in_run
// marks the final word caused by one input unit. cfg channel (cfg_valid/cfg_ready/
// cfg_data) sets the byte capacity per buffer and is always ready.
// the front stage classifies and encodes a unit in the cycle it is accepted and
// pushes the resulting bytes into a short queue; the back stage sends them one a
// cycle while out_ready is high. the first result reaches the out port through the
// queue and then the output register. a unit gives one to seven results, so the
// output port sets the rate. a held high surrogate, or a unit after a stopped
// buffer, gives no results. while the receiver stalls the queue keeps filling and
// in_ready drops only once it is full.
// reset clears counts, the held surrogate, the queue and the output stage, and
// sets the capacity to 65535.
module utf16_to_utf8_encoder_top #(
	parameter int COUNT_WIDTH = u16u8_pkg::COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        first_unit,
	input  logic        last_unit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        is_status,
	output logic [1:0]  stop_cause,
	output logic [15:0] units_consumed,
	output logic [15:0] bytes_written,
	output logic        last_in_run
);

	u16u8_pkg::job_t wr_job;
	u16u8_pkg::job_t rd_job;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;

	u16u8_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code_unit (code_unit),
		.first_unit(first_unit),
		.last_unit (last_unit),
		.q_full    (q_full),
		.push      (push),
		.job       (wr_job)
	);

	u16u8_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(wr_job),
		.full  (q_full),
		.pop   (pop),
		.empty (q_empty),
		.rd_job(rd_job)
	);

	u16u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_job         (rd_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.is_status     (is_status),
		.stop_cause    (stop_cause),
		.units_consumed(units_consumed),
		.bytes_written (bytes_written),
		.last_in_run   (last_in_run)
	);

endmodule

// File: sim/utf8_byte_checker.sv
`timescale 1ns / 100ps

module utf8_byte_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        first_unit,
	input  logic        last_unit,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        is_status,
	input  logic [1:0]  stop_cause,
	input  logic [15:0] units_consumed,
	input  logic [15:0] bytes_written,
	input  logic        last_in_run,
	output int          errors,
	output int          outstanding,
	output int          checked,
	output int          statuses
);

	typedef struct packed {
		logic [7:0]  data;
		logic        status;
		logic [1:0]  cause;
		logic [15:0] units;
		logic [15:0] written;
		logic        last;
	} utf8_word_t;

	utf8_word_t  pending_words[$];

	logic [15:0] capacity;
	logic [15:0] held_high;
	logic        held_valid;
	logic [15:0] byte_count;
	logic [15:0] unit_count;
	logic        stopped;

	function automatic bit room_for(int size);
		return int'(byte_count) + size <= int'(capacity);
	endfunction

	task automatic push_byte(input logic [7:0] b);
		utf8_word_t w;
		w = '0;
		w.data = b;
		pending_words.push_back(w);
	endtask

	task automatic push_status(input logic [1:0] cause);
		utf8_word_t w;
		w = '0;
		w.status = 1'b1;
		w.cause = cause;
		w.units = unit_count;
		w.written = byte_count;
		pending_words.push_back(w);
		stopped = 1'b1;
	endtask

	task automatic push_three(input logic [15:0] v);
		push_byte({4'b1110, v[15:12]});
		push_byte({2'b10, v[11:6]});
		push_byte({2'b10, v[5:0]});
		byte_count = byte_count + 16'd3;
	endtask

	// expected words for one accepted code unit
	task automatic encode_unit(input logic [15:0] cu, input logic first, input logic last);
		int          n0;
		bit          halt;
		logic [20:0] cp;
		n0 = pending_words.size();
		halt = 1'b0;
		if (first) begin
			held_high = '0;
			held_valid = 1'b0;
			byte_count = '0;
			unit_count = '0;
			stopped = 1'b0;
		end
		if (!stopped) begin
			if (held_valid) begin
				if (cu >= u16u8_pkg::SURR_LOW_LO && cu <= u16u8_pkg::SURR_LOW_HI) begin
					if (!room_for(4)) begin
						push_status(u16u8_pkg::CAUSE_ROOM);
					end else begin
						cp = ((held_high - u16u8_pkg::SURR_HIGH_LO) << 10)
							+ (cu - u16u8_pkg::SURR_LOW_LO) + u16u8_pkg::SUPP_BASE;
						push_byte({5'b11110, cp[20:18]});
						push_byte({2'b10, cp[17:12]});
						push_byte({2'b10, cp[11:6]});
						push_byte({2'b10, cp[5:0]});
						byte_count = byte_count + 16'd4;
						unit_count = unit_count + 16'd2;
						held_valid = 1'b0;
						held_high = '0;
						if (last)
							push_status(u16u8_pkg::CAUSE_DONE);
					end
					halt = 1'b1;
				end else if (!room_for(3)) begin
					push_status(u16u8_pkg::CAUSE_ROOM);
					halt = 1'b1;
				end else begin
					// high surrogate without its partner goes out alone
					push_three(held_high);
					unit_count = unit_count + 16'd1;
					held_valid = 1'b0;
					held_high = '0;
				end
			end
			if (!halt) begin
				if (cu < u16u8_pkg::ONE_BYTE_LIM) begin
					if (!room_for(1)) begin
						push_status(u16u8_pkg::CAUSE_ROOM);
						halt = 1'b1;
					end else begin
						push_byte(cu[7:0]);
						byte_count = byte_count + 16'd1;
						unit_count = unit_count + 16'd1;
					end
				end else if (cu < u16u8_pkg::TWO_BYTE_LIM) begin
					if (!room_for(2)) begin
						push_status(u16u8_pkg::CAUSE_ROOM);
						halt = 1'b1;
					end else begin
						push_byte({3'b110, cu[10:6]});
						push_byte({2'b10, cu[5:0]});
						byte_count = byte_count + 16'd2;
						unit_count = unit_count + 16'd1;
					end
				end else if (cu >= u16u8_pkg::SURR_HIGH_LO && cu <= u16u8_pkg::SURR_HIGH_HI) begin
					if (last) begin
						push_status(u16u8_pkg::CAUSE_TRAIL);
						halt = 1'b1;
					end else begin
						held_high = cu;
						held_valid = 1'b1;
					end
				end else begin
					if (!room_for(3)) begin
						push_status(u16u8_pkg::CAUSE_ROOM);
						halt = 1'b1;
					end else begin
						push_three(cu);
						unit_count = unit_count + 16'd1;
					end
				end
				if (!halt && last)
					push_status(u16u8_pkg::CAUSE_DONE);
			end
		end
		if (pending_words.size() > n0)
			pending_words[pending_words.size() - 1].last = 1'b1;
	endtask

	task automatic report(input string msg);
		$display("%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		report($sformatf("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		utf8_word_t want;
		if (!arst_n) begin
			capacity = u16u8_pkg::CAP_RESET;
			held_high = '0;
			held_valid = 1'b0;
			byte_count = '0;
			unit_count = '0;
			stopped = 1'b0;
			pending_words.delete();
			errors = 0;
			outstanding = 0;
			checked = 0;
			statuses = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			if (in_valid && in_ready)
				encode_unit(code_unit, first_unit, last_unit);
			if (out_valid && out_ready) begin
				checked++;
				if (is_status)
					statuses++;
				if (pending_words.size() == 0) begin
					report($sformatf("result word with nothing expected (byte 0x%0h, status %0b)",
						out_byte, is_status));
				end else begin
					want = pending_words.pop_front();
					if (out_byte !== want.data)
						report_mismatch("out_byte", out_byte, want.data);
					if (is_status !== want.status)
						report_mismatch("is_status", is_status, want.status);
					if (stop_cause !== want.cause)
						report_mismatch("stop_cause", stop_cause, want.cause);
					if (units_consumed !== want.units)
						report_mismatch("units_consumed", units_consumed, want.units);
					if (bytes_written !== want.written)
						report_mismatch("bytes_written", bytes_written, want.written);
					if (last_in_run !== want.last)
						report_mismatch("last_in_run", last_in_run, want.last);
				end
			end
			outstanding = pending_words.size();
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] code_unit = '0;
	logic        first_unit = 1'b0;
	logic        last_unit = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        is_status;
	logic [1:0]  stop_cause;
	logic [15:0] units_consumed;
	logic [15:0] bytes_written;
	logic        last_in_run;

	int errors;
	int outstanding;
	int checked;
	int statuses;

	int in_idle_pct = 16;
	int out_idle_pct = 70;
	int units_sent = 0;
	int buffers_sent = 0;
	int cap_writes = 0;

	always #5 clk = ~clk;

	utf16_to_utf8_encoder_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.code_unit      (code_unit),
		.first_unit     (first_unit),
		.last_unit      (last_unit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.is_status      (is_status),
		.stop_cause     (stop_cause),
		.units_consumed (units_consumed),
		.bytes_written  (bytes_written),
		.last_in_run    (last_in_run)
	);

	utf8_byte_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.code_unit      (code_unit),
		.first_unit     (first_unit),
		.last_unit      (last_unit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.is_status      (is_status),
		.stop_cause     (stop_cause),
		.units_consumed (units_consumed),
		.bytes_written  (bytes_written),
		.last_in_run    (last_in_run),
		.errors         (errors),
		.outstanding    (outstanding),
		.checked        (checked),
		.statuses       (statuses)
	);

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	task automatic send_unit(input logic [15:0] cu, input logic first, input logic last);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= cu;
		first_unit <= first;
		last_unit <= last;
		do @(posedge clk); while (!in_ready);
		units_sent++;
	endtask

	// let every expected word drain, plus room for a unit that gives nothing
	task automatic settle();
		int guard;
		in_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (outstanding != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] cap);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	// mostly well-formed text, some stray surrogates and broken framing
	task automatic send_buffer(input int len);
		logic [15:0] text[$];
		int          r;
		int          i;
		logic        first;
		logic        last;
		while (text.size() < len) begin
			r = $urandom_range(99);
			if (r < 30)
				text.push_back(16'($urandom_range(0, 16'h7F)));
			else if (r < 50)
				text.push_back(16'($urandom_range(16'h80, 16'h7FF)));
			else if (r < 68)
				text.push_back(16'($urandom_range(16'h800, 16'hFFFF)));
			else if (r < 88) begin
				text.push_back(16'($urandom_range(u16u8_pkg::SURR_HIGH_LO,
					u16u8_pkg::SURR_HIGH_HI)));
				text.push_back(16'($urandom_range(u16u8_pkg::SURR_LOW_LO,
					u16u8_pkg::SURR_LOW_HI)));
			end else if (r < 94)
				text.push_back(16'($urandom_range(u16u8_pkg::SURR_HIGH_LO,
					u16u8_pkg::SURR_HIGH_HI)));
			else
				text.push_back(16'($urandom_range(u16u8_pkg::SURR_LOW_LO,
					u16u8_pkg::SURR_LOW_HI)));
		end
		for (i = 0; i < text.size(); i++) begin
			first = (i == 0) && ($urandom_range(99) >= 8);
			last = (i == text.size() - 1);
			if ($urandom_range(99) < 5) begin
				first = 1'($urandom_range(1));
				last = 1'($urandom_range(1));
			end
			send_unit(text[i], first, last);
		end
		buffers_sent++;
	endtask

	task automatic random_phase(input int goal);
		while (units_sent < goal)
			send_buffer($urandom_range(1, 12));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every length class, pairs, lone surrogates, trailing high
		write_capacity(u16u8_pkg::CAP_RESET);
		send_unit(16'h0000, 1'b1, 1'b0);
		send_unit(16'h007F, 1'b0, 1'b0);
		send_unit(16'h0080, 1'b0, 1'b0);
		send_unit(16'h07FF, 1'b0, 1'b0);
		send_unit(16'h0800, 1'b0, 1'b0);
		send_unit(16'hFFFF, 1'b0, 1'b0);
		send_unit(u16u8_pkg::SURR_HIGH_LO, 1'b0, 1'b0);
		send_unit(u16u8_pkg::SURR_LOW_LO, 1'b0, 1'b0);
		send_unit(u16u8_pkg::SURR_HIGH_HI, 1'b0, 1'b0);
		send_unit(u16u8_pkg::SURR_LOW_HI, 1'b0, 1'b0);
		send_unit(u16u8_pkg::SURR_LOW_LO, 1'b0, 1'b0);
		send_unit(u16u8_pkg::SURR_HIGH_LO, 1'b0, 1'b0);
		send_unit(16'h0041, 1'b0, 1'b0);
		send_unit(16'hD834, 1'b0, 1'b1);
		// stopped buffer ignores this
		send_unit(16'h0041, 1'b0, 1'b1);
		buffers_sent++;
		settle();

		// out of room: three-byte char, exact-fit pair, held surrogate that does not fit
		write_capacity(16'd4);
		send_unit(16'h0041, 1'b1, 1'b0);
		send_unit(16'h00E9, 1'b0, 1'b0);
		send_unit(16'h0800, 1'b0, 1'b0);
		send_unit(16'h0042, 1'b0, 1'b1);
		send_unit(u16u8_pkg::SURR_HIGH_LO, 1'b1, 1'b0);
		send_unit(u16u8_pkg::SURR_LOW_LO, 1'b0, 1'b0);
		send_unit(16'h0041, 1'b0, 1'b1);
		send_unit(16'h0041, 1'b1, 1'b0);
		send_unit(16'h0042, 1'b0, 1'b0);
		send_unit(u16u8_pkg::SURR_HIGH_LO, 1'b0, 1'b0);
		send_unit(16'h0043, 1'b0, 1'b1);
		buffers_sent += 3;
		settle();

		write_capacity(16'd0);
		send_unit(16'h0000, 1'b1, 1'b1);
		send_unit(u16u8_pkg::SURR_HIGH_HI, 1'b1, 1'b1);
		buffers_sent += 2;
		settle();

		write_capacity(16'($urandom_range(6, 40)));
		random_phase(units_sent + 55);
		settle();

		in_idle_pct = 70;
		out_idle_pct = 16;
		write_capacity(16'($urandom_range(0, 16'hFFFF)));
		random_phase(units_sent + 55);
		settle();

		in_idle_pct = 0;
		out_idle_pct = 0;
		write_capacity(16'($urandom_range(1, 10)));
		random_phase(units_sent + 25);
		settle();
		write_capacity(u16u8_pkg::CAP_RESET);
		random_phase(units_sent + 35);
		settle();
		repeat (20) @(posedge clk);

		$display("%0d code units in %0d buffers under %0d capacity settings", units_sent,
			buffers_sent, cap_writes);
		$display("%0d result words checked, %0d of them status", checked, statuses);
		if (errors == 0 && outstanding == 0) begin
			$display("** utf16_to_utf8_encoder_top: PASSED **");
		end else begin
			$display("** utf16_to_utf8_encoder_top: FAILED **");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout with %0d words still expected", outstanding);
		$display("** utf16_to_utf8_encoder_top: FAILED **");
		$finish;
	end

endmodule
